// ===== src/nbs_pkg.sv =====
`default_nettype none
package nbs_pkg;

  // Default spline degree
  localparam int DEGREE_DEF = 2;
  // Fraction bits of wide values and of weights
  localparam int QF = 30;
  localparam int WF = 24;
  // Wide intermediate width and magnitude width
  localparam int WIDE_W = 58;
  localparam int MAG_W = 56;
  // Result port carries at most three basis functions
  localparam int MAX_RES = 3;
  // Queue depths
  localparam int DESC_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam wide_t CAP = wide_t'(64'sh007F_FFFF_FFFF_FFFF);
  localparam logic [MAG_W-1:0] MAG_CAP = 56'h7F_FFFF_FFFF_FFFF;
  localparam wide_t Q_ONE = wide_t'(64'sh0000_0000_4000_0000);

  typedef struct packed {
    logic signed [31:0] local_param;
    logic signed [31:0] knot_below_span;
    logic signed [31:0] knot_span_start;
    logic signed [31:0] knot_span_end;
    logic signed [31:0] knot_above_span;
    logic [31:0]        weight_first;
    logic [31:0]        weight_middle;
    logic [31:0]        weight_last;
  } item_t;

  typedef struct packed {
    logic [1:0]         basis_index;
    logic signed [31:0] rational_value;
    logic signed [47:0] rational_slope;
    logic               divide_fault;
    logic               last_of_item;
  } result_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic signed [31:0] local_param;
    logic signed [32:0] span_width;
    logic signed [32:0] span_sum;
    logic signed [31:0] knot_below_span;
    logic signed [31:0] knot_span_start;
    logic signed [31:0] knot_span_end;
    logic signed [31:0] knot_above_span;
    logic [31:0]        weight_first;
    logic [31:0]        weight_middle;
    logic [31:0]        weight_last;
  } desc_t;

  typedef struct packed {
    logic  start;
    logic  wshift;
    wide_t a;
    wide_t b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    wide_t y;
  } mul_rsp_t;

  typedef struct packed {
    logic  start;
    wide_t n;
    wide_t d;
  } div_req_t;

  typedef struct packed {
    logic  done;
    logic  zero;
    wide_t y;
  } div_rsp_t;

  // Clamp to the symmetric wide range
  function automatic wide_t sat(input logic signed [63:0] v);
    logic signed [63:0] cap64;
    cap64 = 64'(CAP);
    if (v > cap64) begin
      sat = CAP;
    end else if (v < -cap64) begin
      sat = -CAP;
    end else begin
      sat = wide_t'(v);
    end
  endfunction

  // Magnitude of a wide value
  function automatic logic [MAG_W-1:0] mag(input wide_t v);
    wide_t t;
    t = (v < 0) ? -v : v;
    mag = t[MAG_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/nbs_fifo.sv =====
`default_nettype none
module nbs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             rd,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [AW:0]      cnt;
  logic             wr_en;
  logic             rd_en;

  assign full  = (cnt == (AW+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign wr_en = wr & ~full;
  assign rd_en = rd & ~empty;
  assign rdata = mem[rp];

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr_en) begin
        if (wp == AW'(DEPTH - 1)) wp <= '0;
        else wp <= wp + 1'b1;
      end
      if (rd_en) begin
        if (rp == AW'(DEPTH - 1)) rp <= '0;
        else rp <= rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

  // hold entries
  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wdata;
  end

endmodule
`default_nettype wire

// ===== src/nbs_front.sv =====
`default_nettype none
module nbs_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire nbs_pkg::item_t item,
  input  wire logic           desc_pop,
  output logic                desc_empty,
  output nbs_pkg::desc_t      desc
);

  nbs_pkg::desc_t               cls;
  logic [$bits(nbs_pkg::desc_t)-1:0] rd_bits;

  // classify: span width and span sum for the point mapping
  always_comb begin
    cls.local_param     = item.local_param;
    cls.span_width      = 33'(item.knot_span_end) - 33'(item.knot_span_start);
    cls.span_sum        = 33'(item.knot_span_end) + 33'(item.knot_span_start);
    cls.knot_below_span = item.knot_below_span;
    cls.knot_span_start = item.knot_span_start;
    cls.knot_span_end   = item.knot_span_end;
    cls.knot_above_span = item.knot_above_span;
    cls.weight_first    = item.weight_first;
    cls.weight_middle   = item.weight_middle;
    cls.weight_last     = item.weight_last;
  end

  nbs_fifo #(
    .WIDTH($bits(nbs_pkg::desc_t)),
    .DEPTH(nbs_pkg::DESC_DEPTH)
  ) u_desc_q (
    .clk  (clk),
    .rst  (rst),
    .wr   (push),
    .wdata(cls),
    .full (full),
    .rd   (desc_pop),
    .rdata(rd_bits),
    .empty(desc_empty)
  );

  assign desc = nbs_pkg::desc_t'(rd_bits);

endmodule
`default_nettype wire

// ===== src/nbs_mul.sv =====
`default_nettype none
module nbs_mul (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire nbs_pkg::mul_req_t req,
  output nbs_pkg::mul_rsp_t      rsp
);

  localparam int MW = nbs_pkg::MAG_W;
  localparam int CH = 14;
  localparam int NCH = MW / CH;
  localparam int PW = 2 * MW;

  logic [MW-1:0] am;
  logic [MW-1:0] bm;
  logic          neg;
  logic          wsh;
  logic [PW-1:0] acc;
  logic [2:0]    cnt;
  logic          busy;
  logic [PW-1:0] fl;
  logic [PW-1:0] rs;
  logic          rb;
  logic [MW-1:0] mres;
  logic [MW+CH-1:0] pp;
  nbs_pkg::wide_t yv;

  // partial product of a by the current top slice of b
  always_comb begin
    pp = {{CH{1'b0}}, am} * {{MW{1'b0}}, bm[MW-1 -: CH]};
  end

  // round the product magnitude and limit it
  always_comb begin
    if (wsh) begin
      fl = acc >> nbs_pkg::WF;
      rb = acc[nbs_pkg::WF-1];
    end else begin
      fl = acc >> nbs_pkg::QF;
      rb = acc[nbs_pkg::QF-1];
    end
    rs = fl + PW'(rb);
    mres = (rs > PW'(nbs_pkg::MAG_CAP)) ? nbs_pkg::MAG_CAP : rs[MW-1:0];
    yv = nbs_pkg::wide_t'({2'b00, mres});
    if (neg) yv = -yv;
  end

  // accumulate one 14-bit slice of b per cycle, top slice first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        am   <= nbs_pkg::mag(req.a);
        bm   <= nbs_pkg::mag(req.b);
        neg  <= req.a[nbs_pkg::WIDE_W-1] ^ req.b[nbs_pkg::WIDE_W-1];
        wsh  <= req.wshift;
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt != 3'(NCH)) begin
          acc <= (acc << CH) + PW'(pp);
          bm  <= bm << CH;
          cnt <= cnt + 1'b1;
        end else begin
          rsp.y    <= yv;
          rsp.done <= 1'b1;
          busy     <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/nbs_div.sv =====
`default_nettype none
module nbs_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire nbs_pkg::div_req_t req,
  output nbs_pkg::div_rsp_t      rsp
);

  localparam int MW = nbs_pkg::MAG_W;
  localparam int DW = MW + nbs_pkg::QF + 1;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd;
  logic [MW-1:0] dm;
  logic [MW-1:0] rem;
  logic [DW-1:0] q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          neg;
  logic [MW:0]   rem_sh;
  logic [DW-1:0] rs;
  logic [MW-1:0] mres;
  nbs_pkg::wide_t yv;

  // shifted partial remainder and rounded, limited quotient
  always_comb begin
    rem_sh = {rem, dvd[DW-1]};
    rs = (q >> 1) + DW'(q[0]);
    mres = (rs > DW'(nbs_pkg::MAG_CAP)) ? nbs_pkg::MAG_CAP : rs[MW-1:0];
    yv = nbs_pkg::wide_t'({2'b00, mres});
    if (neg) yv = -yv;
  end

  // restoring division, one quotient bit per cycle, one extra bit for rounding
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        if (req.d == '0) begin
          rsp.y    <= '0;
          rsp.zero <= 1'b1;
          rsp.done <= 1'b1;
        end else begin
          dvd      <= {nbs_pkg::mag(req.n), (nbs_pkg::QF + 1)'(0)};
          dm       <= nbs_pkg::mag(req.d);
          rem      <= '0;
          q        <= '0;
          cnt      <= '0;
          neg      <= req.n[nbs_pkg::WIDE_W-1] ^ req.d[nbs_pkg::WIDE_W-1];
          rsp.zero <= 1'b0;
          busy     <= 1'b1;
        end
      end else if (busy) begin
        if (cnt != CW'(DW)) begin
          if (rem_sh >= {1'b0, dm}) begin
            rem <= MW'(rem_sh - {1'b0, dm});
            q   <= {q[DW-2:0], 1'b1};
          end else begin
            rem <= rem_sh[MW-1:0];
            q   <= {q[DW-2:0], 1'b0};
          end
          dvd <= dvd << 1;
          cnt <= cnt + 1'b1;
        end else begin
          rsp.y    <= yv;
          rsp.done <= 1'b1;
          busy     <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/nbs_back.sv =====
`default_nettype none
module nbs_back #(
  parameter int DEGREE = nbs_pkg::DEGREE_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           desc_empty,
  output logic                desc_pop,
  input  wire nbs_pkg::desc_t desc,
  input  wire logic           res_full,
  output logic                res_push,
  output nbs_pkg::result_t    res
);

  localparam int NB = DEGREE + 1;
  localparam int IW = $clog2(DEGREE + 1);
  localparam int NRES = (NB < nbs_pkg::MAX_RES) ? NB : nbs_pkg::MAX_RES;
  localparam logic signed [63:0] DEG64 = 64'(DEGREE);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_X0   = 5'd1;
  localparam logic [4:0] ST_X1   = 5'd2;
  localparam logic [4:0] ST_J0   = 5'd3;
  localparam logic [4:0] ST_R0   = 5'd4;
  localparam logic [4:0] ST_R1   = 5'd5;
  localparam logic [4:0] ST_R2   = 5'd6;
  localparam logic [4:0] ST_R3   = 5'd7;
  localparam logic [4:0] ST_D0   = 5'd8;
  localparam logic [4:0] ST_D1   = 5'd9;
  localparam logic [4:0] ST_D2   = 5'd10;
  localparam logic [4:0] ST_D3   = 5'd11;
  localparam logic [4:0] ST_D4   = 5'd12;
  localparam logic [4:0] ST_D5   = 5'd13;
  localparam logic [4:0] ST_D6   = 5'd14;
  localparam logic [4:0] ST_S0   = 5'd15;
  localparam logic [4:0] ST_S1   = 5'd16;
  localparam logic [4:0] ST_S2   = 5'd17;
  localparam logic [4:0] ST_E0   = 5'd18;
  localparam logic [4:0] ST_E1   = 5'd19;
  localparam logic [4:0] ST_E2   = 5'd20;
  localparam logic [4:0] ST_E3   = 5'd21;
  localparam logic [4:0] ST_E4   = 5'd22;

  logic [4:0]        state;
  logic [4:0]        state_next;
  nbs_pkg::desc_t    d;
  logic              fault;
  logic [IW-1:0]     j;
  logic [IW-1:0]     r;
  logic [1:0]        i;
  nbs_pkg::wide_t    xsi;
  nbs_pkg::wide_t    saved;
  nbs_pkg::wide_t    tmp;
  nbs_pkg::wide_t    up;
  nbs_pkg::wide_t    dn;
  nbs_pkg::wide_t    dphi;
  nbs_pkg::wide_t    wsr;
  nbs_pkg::wide_t    ws1r;
  nbs_pkg::wide_t    ratio;
  nbs_pkg::wide_t    rv;
  nbs_pkg::wide_t    q2;
  nbs_pkg::wide_t    sl;
  logic signed [63:0] acc;
  logic signed [63:0] acc1;
  nbs_pkg::wide_t    lft  [NB];
  nbs_pkg::wide_t    rgt  [NB];
  nbs_pkg::wide_t    col  [NB];
  nbs_pkg::wide_t    prev [NB];
  nbs_pkg::wide_t    low  [NB];
  nbs_pkg::wide_t    wphi [nbs_pkg::MAX_RES];
  nbs_pkg::wide_t    wd   [nbs_pkg::MAX_RES];

  nbs_pkg::mul_req_t mreq;
  nbs_pkg::mul_rsp_t mrsp;
  nbs_pkg::div_req_t dreq;
  nbs_pkg::div_rsp_t drsp;

  logic [IW-1:0]      r_inc;
  logic [IW-1:0]      j_m_r;
  logic [IW-1:0]      r_dec;
  logic [1:0]         r2;
  logic signed [31:0] kl;
  logic signed [31:0] kr;
  nbs_pkg::wide_t     den;
  nbs_pkg::wide_t     wr;
  logic signed [63:0] so64;
  logic signed [63:0] rv64;

  nbs_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  nbs_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // index arithmetic and operand selection
  always_comb begin
    r_inc = r + 1'b1;
    j_m_r = j - r;
    r_dec = r - 1'b1;
    r2    = 2'(r);
    kl    = (j == IW'(1)) ? d.knot_span_start : d.knot_below_span;
    kr    = (j == IW'(1)) ? d.knot_span_end : d.knot_above_span;
    den   = nbs_pkg::sat(64'(rgt[r_inc]) + 64'(lft[j_m_r]));
    if (r == '0) begin
      wr = nbs_pkg::wide_t'({(nbs_pkg::WIDE_W-32)'(0), d.weight_first});
    end else if (r == IW'(1)) begin
      wr = nbs_pkg::wide_t'({(nbs_pkg::WIDE_W-32)'(0), d.weight_middle});
    end else begin
      wr = nbs_pkg::wide_t'({(nbs_pkg::WIDE_W-32)'(0), d.weight_last});
    end
  end

  // format one result
  always_comb begin
    so64 = (64'(sl) + 64'sd32) >>> 6;
    if (so64 > 64'sh0000_7FFF_FFFF_FFFF) so64 = 64'sh0000_7FFF_FFFF_FFFF;
    if (so64 < -64'sh0000_8000_0000_0000) so64 = -64'sh0000_8000_0000_0000;
    rv64 = 64'(rv);
    if (rv64 > 64'sd2147483647) rv64 = 64'sd2147483647;
    if (rv64 < -64'sd2147483648) rv64 = -64'sd2147483648;
    res.basis_index    = i;
    res.rational_value = 32'(rv64);
    res.rational_slope = 48'(so64);
    res.divide_fault   = fault;
    res.last_of_item   = (i == 2'(NRES - 1));
  end

  // sequence control and unit requests
  always_comb begin
    state_next = state;
    mreq       = '0;
    dreq       = '0;
    desc_pop   = 1'b0;
    res_push   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!desc_empty) begin
          desc_pop   = 1'b1;
          state_next = ST_X0;
        end
      end
      ST_X0: begin
        mreq.start = 1'b1;
        mreq.a     = nbs_pkg::wide_t'(d.span_width);
        mreq.b     = nbs_pkg::wide_t'(d.local_param);
        state_next = ST_X1;
      end
      ST_X1: if (mrsp.done) state_next = ST_J0;
      ST_J0: state_next = ST_R0;
      ST_R0: begin
        dreq.start = 1'b1;
        dreq.n     = col[r];
        dreq.d     = den;
        state_next = ST_R1;
      end
      ST_R1: begin
        if (drsp.done) begin
          mreq.start = 1'b1;
          mreq.a     = rgt[r_inc];
          mreq.b     = drsp.y;
          state_next = ST_R2;
        end
      end
      ST_R2: begin
        if (mrsp.done) begin
          mreq.start = 1'b1;
          mreq.a     = lft[j_m_r];
          mreq.b     = tmp;
          state_next = ST_R3;
        end
      end
      ST_R3: begin
        if (mrsp.done) begin
          if (r == IW'(j - 1'b1)) begin
            state_next = (j == IW'(DEGREE)) ? ST_D0 : ST_J0;
          end else begin
            state_next = ST_R0;
          end
        end
      end
      ST_D0: begin
        if (r != '0) begin
          dreq.start = 1'b1;
          dreq.n     = prev[r_dec];
          dreq.d     = low[r_dec];
          state_next = ST_D1;
        end else begin
          state_next = ST_D2;
        end
      end
      ST_D1: if (drsp.done) state_next = ST_D2;
      ST_D2: begin
        if (r != IW'(DEGREE)) begin
          dreq.start = 1'b1;
          dreq.n     = prev[r];
          dreq.d     = low[r];
          state_next = ST_D3;
        end else begin
          state_next = ST_D4;
        end
      end
      ST_D3: if (drsp.done) state_next = ST_D4;
      ST_D4: begin
        mreq.start  = 1'b1;
        mreq.wshift = 1'b1;
        mreq.a      = col[r];
        mreq.b      = wr;
        state_next  = ST_D5;
      end
      ST_D5: begin
        if (mrsp.done) begin
          mreq.start  = 1'b1;
          mreq.wshift = 1'b1;
          mreq.a      = dphi;
          mreq.b      = wr;
          state_next  = ST_D6;
        end
      end
      ST_D6: begin
        if (mrsp.done) state_next = (r == IW'(DEGREE)) ? ST_S0 : ST_D0;
      end
      ST_S0: state_next = ST_S1;
      ST_S1: begin
        dreq.start = 1'b1;
        dreq.n     = ws1r;
        dreq.d     = wsr;
        state_next = ST_S2;
      end
      ST_S2: if (drsp.done) state_next = ST_E0;
      ST_E0: begin
        dreq.start = 1'b1;
        dreq.n     = wphi[i];
        dreq.d     = wsr;
        state_next = ST_E1;
      end
      ST_E1: begin
        if (drsp.done) begin
          dreq.start = 1'b1;
          dreq.n     = wd[i];
          dreq.d     = wsr;
          state_next = ST_E2;
        end
      end
      ST_E2: begin
        if (drsp.done) begin
          mreq.start = 1'b1;
          mreq.a     = rv;
          mreq.b     = ratio;
          state_next = ST_E3;
        end
      end
      ST_E3: if (mrsp.done) state_next = ST_E4;
      ST_E4: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = (i == 2'(NRES - 1)) ? ST_IDLE : ST_E0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // advance state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!desc_empty) begin
          d     <= desc;
          fault <= 1'b0;
        end
      end
      ST_X1: begin
        if (mrsp.done) begin
          xsi    <= nbs_pkg::sat((64'(mrsp.y) + 64'(d.span_sum)) >>> 1);
          col[0] <= nbs_pkg::Q_ONE;
          j      <= IW'(1);
        end
      end
      ST_J0: begin
        lft[j] <= nbs_pkg::sat(64'(xsi) - 64'(kl));
        rgt[j] <= nbs_pkg::sat(64'(kr) - 64'(xsi));
        saved  <= '0;
        r      <= '0;
      end
      ST_R0: begin
        low[r]  <= den;
        prev[r] <= col[r];
      end
      ST_R1: begin
        if (drsp.done) begin
          tmp   <= drsp.y;
          fault <= fault | drsp.zero;
        end
      end
      ST_R2: begin
        if (mrsp.done) col[r] <= nbs_pkg::sat(64'(saved) + 64'(mrsp.y));
      end
      ST_R3: begin
        if (mrsp.done) begin
          if (r == IW'(j - 1'b1)) begin
            col[j] <= mrsp.y;
            if (j == IW'(DEGREE)) begin
              r    <= '0;
              acc  <= '0;
              acc1 <= '0;
            end else begin
              j <= j + 1'b1;
            end
          end else begin
            saved <= mrsp.y;
            r     <= r_inc;
          end
        end
      end
      ST_D0: if (r == '0) up <= '0;
      ST_D1: begin
        if (drsp.done) begin
          up    <= drsp.y;
          fault <= fault | drsp.zero;
        end
      end
      ST_D2: if (r == IW'(DEGREE)) dn <= '0;
      ST_D3: begin
        if (drsp.done) begin
          dn    <= drsp.y;
          fault <= fault | drsp.zero;
        end
      end
      ST_D4: dphi <= nbs_pkg::sat((64'(up) - 64'(dn)) * DEG64);
      ST_D5: begin
        if (mrsp.done) begin
          if (int'(r) < nbs_pkg::MAX_RES) wphi[r2] <= mrsp.y;
          acc <= acc + 64'(mrsp.y);
        end
      end
      ST_D6: begin
        if (mrsp.done) begin
          if (int'(r) < nbs_pkg::MAX_RES) wd[r2] <= mrsp.y;
          acc1 <= acc1 + 64'(mrsp.y);
          if (r != IW'(DEGREE)) r <= r_inc;
        end
      end
      ST_S0: begin
        wsr  <= nbs_pkg::sat(acc);
        ws1r <= nbs_pkg::sat(acc1);
      end
      ST_S2: begin
        if (drsp.done) begin
          ratio <= drsp.y;
          fault <= fault | drsp.zero;
          i     <= '0;
        end
      end
      ST_E1: begin
        if (drsp.done) begin
          rv    <= drsp.y;
          fault <= fault | drsp.zero;
        end
      end
      ST_E2: begin
        if (drsp.done) begin
          q2    <= drsp.y;
          fault <= fault | drsp.zero;
        end
      end
      ST_E3: if (mrsp.done) sl <= nbs_pkg::sat(64'(q2) - 64'(mrsp.y));
      ST_E4: if (!res_full) i <= i + 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/nurbs_basis_and_slope_core.sv =====
`default_nettype none
// Rational B-spline basis values and slopes on one knot span.
// Input channel: drive item and push; the item is taken on a clock edge with
// push high and full low. A two-entry request queue sits behind the port, so
// new requests are taken while earlier ones are still being worked on.
// Result channel: while empty is low the oldest result sits on result; pop
// takes it. Each request gives min(DEGREE+1, 3) results, basis_index 0 up,
// with last_of_item set on the final one.
// Arithmetic: products run on one shared 56x14 multiplier (the scaling by the
// degree apart) and quotients on one shared restoring divider.
// A request needs D(D+1)/2 + 2D + 1 + 2*min(D+1,3) quotients for D = DEGREE,
// 14 at degree 2; the sequencer works on one request at a time, while the
// request queue goes on taking new ones.
// Reset clears both queues and the sequencer; no clearing pass is needed.
// A stalled result side fills a two-entry result queue, then the sequencer
// holds its finished result until room opens; the input queue keeps filling.
module nurbs_basis_and_slope_core #(
  parameter int DEGREE = nbs_pkg::DEGREE_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire nbs_pkg::item_t item,
  output logic                empty,
  input  wire logic           pop,
  output nbs_pkg::result_t    result
);

  logic                                   desc_pop;
  logic                                   desc_empty;
  nbs_pkg::desc_t                         desc;
  logic                                   res_full;
  logic                                   res_push;
  nbs_pkg::result_t                       res;
  logic [$bits(nbs_pkg::result_t)-1:0]    res_bits;

  nbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .desc_pop  (desc_pop),
    .desc_empty(desc_empty),
    .desc      (desc)
  );

  nbs_back #(.DEGREE(DEGREE)) u_back (
    .clk       (clk),
    .rst       (rst),
    .desc_empty(desc_empty),
    .desc_pop  (desc_pop),
    .desc      (desc),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  nbs_fifo #(
    .WIDTH($bits(nbs_pkg::result_t)),
    .DEPTH(nbs_pkg::RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .wr   (res_push),
    .wdata(res),
    .full (res_full),
    .rd   (pop),
    .rdata(res_bits),
    .empty(empty)
  );

  assign result = nbs_pkg::result_t'(res_bits);

endmodule
`default_nettype wire

// ===== src/nbs_check.sv =====
`default_nettype none
module nbs_check #(
  parameter int DEGREE = nbs_pkg::DEGREE_DEF
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             push,
  input wire logic             full,
  input wire logic             empty,
  input wire logic             pop,
  input wire nbs_pkg::result_t result
);

  localparam int NRES = (DEGREE + 1 < nbs_pkg::MAX_RES) ? DEGREE + 1 : nbs_pkg::MAX_RES;
  localparam logic [1:0] LAST_IDX = 2'(NRES - 1);

  // reset drains the result side
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // final result of a request carries the top basis index
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.last_of_item) |-> (result.basis_index == LAST_IDX))
    else $error("last_of_item on wrong basis index");

  // earlier results never carry the top index or a code past it
  a_mid_index: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.last_of_item) |->
      (result.basis_index != LAST_IDX && result.basis_index != 2'd3))
    else $error("basis index out of order");

  // held result stays put while not taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while stalled");

  // after a push while full, full either holds or drops
  a_push_ok: assert property (@(posedge clk) disable iff (rst)
    (push && full) |=> $stable(full) || !full)
    else $error("full state inconsistent");

endmodule

bind nurbs_basis_and_slope_core nbs_check #(.DEGREE(DEGREE)) u_check (
  .clk   (clk),
  .rst   (rst),
  .push  (push),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .result(result)
);
`default_nettype wire

// ===== tb/nurbs_basis_and_slope_core_test.sv =====
`timescale 1ns / 1ps
module nurbs_basis_and_slope_core_test;

  localparam longint WCAP = 64'sh007F_FFFF_FFFF_FFFF;
  localparam int N_RAND = 400;
  localparam int HOLD_CYCLES = 8000;
  localparam int STALL_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 3000;

  logic clk;
  logic rst;
  logic push;
  logic full;
  nbs_pkg::item_t item;
  logic empty;
  logic pop;
  nbs_pkg::result_t result;

  nurbs_basis_and_slope_core dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

  // Directed request row; fixed rows carry hand-derived results
  typedef struct {
    nbs_pkg::item_t req;
    bit fixed;
    logic signed [31:0] fix_value;
    logic signed [47:0] fix_slope;
    bit fix_fault;
  } stim_row_t;

  nbs_pkg::result_t basis_results_q[$];
  bit zero_divisor;
  int mismatches = 0;
  int sent = 0;
  int received = 0;
  bit tail_phase = 0;
  bit sender_done = 0;
  int stall_count = 0;
  bit long_hold_done = 0;

  // Clock
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Wide saturation to +-(2^55 - 1)
  function automatic longint clamp_wide(longint v);
    if (v > WCAP) return WCAP;
    if (v < -WCAP) return -WCAP;
    return v;
  endfunction

  function automatic longint abs_wide(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Rounded, capped product shifted right by sh
  function automatic longint fx_mul(longint a, longint b, int sh);
    logic [127:0] p;
    logic [127:0] r;
    longint m;
    p = 128'(abs_wide(a)) * 128'(abs_wide(b));
    r = p >> sh;
    if (r >= 128'(WCAP)) begin
      m = WCAP;
    end else begin
      r = r + p[sh-1];
      m = (r > 128'(WCAP)) ? WCAP : longint'(r);
    end
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  // Rounded, capped Q.30 quotient; a zero divisor flags and yields 0
  function automatic longint fx_div(longint n, longint d);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    logic [127:0] rem;
    longint m;
    if (d == 0) begin
      zero_divisor = 1;
      return 0;
    end
    num = 128'(abs_wide(n)) << nbs_pkg::QF;
    den = 128'(abs_wide(d));
    q = num / den;
    rem = num % den;
    if (q > 128'(WCAP)) begin
      m = WCAP;
    end else begin
      if ((rem << 1) >= den) q = q + 1;
      m = (q > 128'(WCAP)) ? WCAP : longint'(q);
    end
    return ((n < 0) != (d < 0)) ? -m : m;
  endfunction

  // Compute the three rational basis results of one request
  function automatic void predict_basis(nbs_pkg::item_t it);
    longint kn[4];
    longint wt[3];
    longint lft[3];
    longint rgt[3];
    longint bf[3][3];
    longint wphi[3];
    longint wd[3];
    longint up, dn, dphi, xsi, saved, tmp, ws, ws1, ratio, rv, sl, so, vo;
    int ki;
    nbs_pkg::result_t res;
    zero_divisor = 0;
    kn[0] = it.knot_below_span;
    kn[1] = it.knot_span_start;
    kn[2] = it.knot_span_end;
    kn[3] = it.knot_above_span;
    wt[0] = longint'({32'd0, it.weight_first});
    wt[1] = longint'({32'd0, it.weight_middle});
    wt[2] = longint'({32'd0, it.weight_last});
    xsi = clamp_wide((fx_mul(kn[2] - kn[1], it.local_param, nbs_pkg::QF)
                      + kn[1] + kn[2]) >>> 1);
    foreach (bf[a, b]) bf[a][b] = 0;
    foreach (lft[a]) begin
      lft[a] = 0;
      rgt[a] = 0;
    end
    bf[0][0] = 64'sd1 << nbs_pkg::QF;
    // Build the basis triangle, clamping knot offsets to the given four
    for (int j = 1; j <= 2; j++) begin
      ki = 1 - j;
      if (ki < -1) ki = -1;
      lft[j] = clamp_wide(xsi - kn[ki + 1]);
      ki = (j > 2) ? 2 : j;
      rgt[j] = clamp_wide(kn[ki + 1] - xsi);
      saved = 0;
      for (int r = 0; r < j; r++) begin
        bf[j][r] = clamp_wide(rgt[r + 1] + lft[j - r]);
        tmp = fx_div(bf[r][j - 1], bf[j][r]);
        bf[r][j] = clamp_wide(saved + fx_mul(rgt[r + 1], tmp, nbs_pkg::QF));
        saved = fx_mul(lft[j - r], tmp, nbs_pkg::QF);
      end
      bf[j][j] = saved;
    end
    // Weighted values and slopes
    ws = 0;
    ws1 = 0;
    for (int r = 0; r <= 2; r++) begin
      up = 0;
      dn = 0;
      if (r >= 1) up = fx_div(bf[r - 1][1], bf[2][r - 1]);
      if (r < 2) dn = fx_div(bf[r][1], bf[2][r]);
      dphi = clamp_wide(2 * (up - dn));
      wphi[r] = fx_mul(bf[r][2], wt[r], nbs_pkg::WF);
      wd[r] = fx_mul(dphi, wt[r], nbs_pkg::WF);
      ws += wphi[r];
      ws1 += wd[r];
    end
    ws = clamp_wide(ws);
    ws1 = clamp_wide(ws1);
    ratio = fx_div(ws1, ws);
    for (int i = 0; i < 3; i++) begin
      rv = fx_div(wphi[i], ws);
      sl = clamp_wide(fx_div(wd[i], ws) - fx_mul(rv, ratio, nbs_pkg::QF));
      so = (sl + 32) >>> 6;
      vo = rv;
      if (vo > 64'sd2147483647) vo = 64'sd2147483647;
      if (vo < -64'sd2147483648) vo = -64'sd2147483648;
      if (so > (64'sd1 <<< 47) - 1) so = (64'sd1 <<< 47) - 1;
      if (so < -(64'sd1 <<< 47)) so = -(64'sd1 <<< 47);
      res.basis_index = 2'(i);
      res.rational_value = vo[31:0];
      res.rational_slope = so[47:0];
      res.last_of_item = (i == 2);
      res.divide_fault = 0;
      basis_results_q.push_back(res);
    end
    // Fault covers every result of the request
    for (int i = 0; i < 3; i++)
      basis_results_q[basis_results_q.size() - 1 - i].divide_fault = zero_divisor;
  endfunction

  function automatic nbs_pkg::item_t make_req(longint p, longint k0, longint k1, longint k2,
                                              longint k3, longint w0, longint w1,
                                              longint w2);
    nbs_pkg::item_t it;
    it.local_param = p[31:0];
    it.knot_below_span = k0[31:0];
    it.knot_span_start = k1[31:0];
    it.knot_span_end = k2[31:0];
    it.knot_above_span = k3[31:0];
    it.weight_first = w0[31:0];
    it.weight_middle = w1[31:0];
    it.weight_last = w2[31:0];
    return it;
  endfunction

  // Well-formed span with random content, or raw noise
  function automatic nbs_pkg::item_t random_req();
    nbs_pkg::item_t it;
    logic signed [31:0] k[4];
    logic signed [31:0] t;
    if ($urandom_range(0, 4) == 0) begin
      it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return it;
    end
    foreach (k[i]) k[i] = $signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000;
    // Sort knots ascending
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3 - i; j++)
        if (k[j] > k[j + 1]) begin
          t = k[j];
          k[j] = k[j + 1];
          k[j + 1] = t;
        end
    if ($urandom_range(0, 15) == 0) k[2] = k[1];
    it.local_param = $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    it.knot_below_span = k[0];
    it.knot_span_start = k[1];
    it.knot_span_end = k[2];
    it.knot_above_span = k[3];
    it.weight_first = $urandom_range(32'h0010_0000, 32'h0400_0000);
    it.weight_middle = $urandom_range(32'h0010_0000, 32'h0400_0000);
    it.weight_last = $urandom_range(32'h0010_0000, 32'h0400_0000);
    if ($urandom_range(0, 9) == 0) it.weight_middle = $urandom;
    return it;
  endfunction

  // Offer one request and hold it until taken
  task automatic send_req(nbs_pkg::item_t it, bit with_idle);
    if (with_idle && $urandom_range(0, 3) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push <= 1;
    item <= it;
    do @(posedge clk); while (full);
    sent++;
  endtask

  // Reset and request stream
  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    longint one;
    one = 64'sd1 << 30;
    rst = 1;
    push = 0;
    item = '0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    row = '{default: 0};
    // All knots equal, no weight: every divisor is zero
    row.req = make_req(0, 0, 0, 0, 0, 0, 0, 0);
    row.fixed = 1;
    row.fix_fault = 1;
    rows.push_back(row);
    // Good knots but zero weights: weight sum is zero
    row.req = make_req(one / 2, -one, 0, one, 2 * one, 0, 0, 0);
    rows.push_back(row);
    row = '{default: 0};
    row.req = make_req(-one, -one, 0, one, 2 * one, 1 << 24, 1 << 24, 1 << 24);
    rows.push_back(row);
    row.req = make_req(0, -one, 0, one, 2 * one, 1 << 24, 1 << 24, 1 << 24);
    rows.push_back(row);
    row.req = make_req(one, -one, 0, one, 2 * one, 1 << 24, 1 << 24, 1 << 24);
    rows.push_back(row);
    row.req = make_req(one / 3, -one, 0, one, 2 * one, 1 << 24, 3 << 23, 1 << 25);
    rows.push_back(row);
    row.req = make_req(32'h7FFF_FFFF, -one, 0, one, 2 * one, 1 << 24, 1 << 24, 1 << 24);
    rows.push_back(row);
    row.req = make_req(-64'sd2147483648, -one, 0, one, 2 * one, 1 << 24, 1 << 24, 1 << 24);
    rows.push_back(row);
    // Extreme knots and weights
    row.req = make_req(0, -64'sd2147483648, -64'sd2147483648, 64'sd2147483647,
                       64'sd2147483647, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    rows.push_back(row);
    row.req = make_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    rows.push_back(row);
    row.req = make_req(one / 2, -one, 0, one, 2 * one, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
    rows.push_back(row);
    // Zero-length span, repeated outer knots, descending knots
    row.req = make_req(one / 4, -one, one / 2, one / 2, one, 1 << 24, 1 << 24, 1 << 24);
    rows.push_back(row);
    row.req = make_req(one / 4, 0, 0, one, one, 1 << 24, 1 << 24, 1 << 24);
    rows.push_back(row);
    row.req = make_req(-one / 4, 2 * one, one, 0, -one, 1 << 24, 1 << 24, 1 << 24);
    rows.push_back(row);
    row.req = make_req(one / 8, -one / 2, -one / 4, -one / 4 + 1, one, 1 << 20, 1 << 30, 7);
    rows.push_back(row);
    row.req = make_req(3 * one / 4, one / 8, one / 4, one / 2, one / 2 + 1,
                       1 << 24, 0, 1 << 24);
    rows.push_back(row);

    foreach (rows[i]) begin
      if (rows[i].fixed) begin
        for (int b = 0; b < 3; b++)
          basis_results_q.push_back('{basis_index: 2'(b),
                                      rational_value: rows[i].fix_value,
                                      rational_slope: rows[i].fix_slope,
                                      divide_fault: rows[i].fix_fault,
                                      last_of_item: (b == 2)});
      end else begin
        predict_basis(rows[i].req);
      end
      send_req(rows[i].req, 1);
    end

    for (int n = 0; n < N_RAND; n++) begin
      nbs_pkg::item_t it;
      it = random_req();
      if (n == N_RAND / 2) begin
        // Pause until the block has drained
        push <= 0;
        while (basis_results_q.size() != 0) @(posedge clk);
      end
      if (n == N_RAND - 40) tail_phase = 1;
      predict_basis(it);
      send_req(it, !tail_phase);
    end
    push <= 0;
    sender_done = 1;
  end

  // Result side: random bursts of idling, one long hold early on
  initial begin
    pop = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!long_hold_done && received >= 30) begin
        long_hold_done = 1;
        pop <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
        pop <= 0;
        repeat ($urandom_range(1, 3) - 1) @(posedge clk);
      end else begin
        pop <= 1;
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      nbs_pkg::result_t want;
      received++;
      if (basis_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", result);
      end else begin
        want = basis_results_q.pop_front();
        if (result.basis_index !== want.basis_index ||
            result.rational_value !== want.rational_value ||
            result.rational_slope !== want.rational_slope ||
            result.divide_fault !== want.divide_fault ||
            result.last_of_item !== want.last_of_item) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected idx=%0d val=%h slope=%h fault=%b last=%b,",
                     want.basis_index, want.rational_value, want.rational_slope,
                     want.divide_fault, want.last_of_item,
                     " got idx=%0d val=%h slope=%h fault=%b last=%b",
                     result.basis_index, result.rational_value, result.rational_slope,
                     result.divide_fault, result.last_of_item);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Drain and report
  initial begin
    wait (sender_done);
    while (basis_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && basis_results_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
